// File: rtl/atrf_pkg.sv
// ---------------------------------------------------------------------------
// atrf_pkg: shared types and constants of the transmit-request framer
// Frame byte codes, byte positions, register indexes and the command
// that travels from the front classifier to the back emitter.
// ---------------------------------------------------------------------------
package atrf_pkg;

    localparam int LEN_W = 9;
    localparam int POS_W = 5;
    localparam int ADDR_W = 64;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 9'd256;
    localparam logic [15:0] LEN_OVERHEAD = 16'd14;

    localparam logic [7:0] SOF_BYTE = 8'h7E;
    localparam logic [7:0] TX_REQ_TYPE = 8'h10;

    localparam logic [7:0] SEQ_ID_RST = 8'h01;
    localparam logic [15:0] SHORT_ADDR_RST = 16'hFFFE;
    localparam logic [7:0] RADIUS_RST = 8'h00;
    localparam logic [7:0] OPTIONS_RST = 8'h00;

    // register indexes
    localparam logic [1:0] REG_SEQ_ID = 2'd0;
    localparam logic [1:0] REG_SHORT_ADDR = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_OPTIONS = 2'd3;

    // byte positions within one frame
    localparam logic [POS_W-1:0] POS_DELIM = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE = 5'd3;
    localparam logic [POS_W-1:0] POS_SEQ_ID = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR7 = 5'd5;
    localparam logic [POS_W-1:0] POS_ADDR6 = 5'd6;
    localparam logic [POS_W-1:0] POS_ADDR5 = 5'd7;
    localparam logic [POS_W-1:0] POS_ADDR4 = 5'd8;
    localparam logic [POS_W-1:0] POS_ADDR3 = 5'd9;
    localparam logic [POS_W-1:0] POS_ADDR2 = 5'd10;
    localparam logic [POS_W-1:0] POS_ADDR1 = 5'd11;
    localparam logic [POS_W-1:0] POS_ADDR0 = 5'd12;
    localparam logic [POS_W-1:0] POS_SHORT_HI = 5'd13;
    localparam logic [POS_W-1:0] POS_SHORT_LO = 5'd14;
    localparam logic [POS_W-1:0] POS_RADIUS = 5'd15;
    localparam logic [POS_W-1:0] POS_OPTIONS = 5'd16;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd17;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 5'd18;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic              hdr;          // open a frame: emit the header first
        logic              has_payload;  // carry one payload byte
        logic              last;         // close the frame with the checksum
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        payload;
    } atrf_cmd_t;

    typedef struct packed {
        logic [7:0]  seq_id;
        logic [15:0] short_addr;
        logic [7:0]  radius;
        logic [7:0]  options;
    } atrf_cfg_t;

endpackage

// File: rtl/api_tx_request_framer_core.sv
// ---------------------------------------------------------------------------
// api_tx_request_framer_core: transmit-request frame builder, byte stream out
// Path: an opening beat goes into the queue, then out through the output register.
// Throughput: one output byte per cycle unless frame_ready stalls the output, set
//   by the emitter's single byte position counter; a frame-opening beat emits the
//   header, every later payload beat its byte, the closing beat the checksum too.
// Reset: rst_n clears the frame tracker, the queue and the output valid flag;
//   the configuration registers return to their documented defaults.
// ---------------------------------------------------------------------------
module api_tx_request_framer_core
    import atrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input beats
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [7:0]       payload_byte,
    input  logic [LEN_W-1:0] payload_len,
    input  logic [63:0]      dest_addr,
    // output beats
    output logic             frame_valid,
    input  logic             frame_ready,
    output logic [7:0]       frame_byte,
    output logic             frame_last
);

    atrf_cfg_t cfg_reg;
    logic      cfg_wr;
    logic [1:0] reg_idx;

    logic      push;
    logic      push_ready;
    atrf_cmd_t push_cmd;
    logic      pop;
    logic      head_valid;
    atrf_cmd_t head_cmd;

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this; the emitter reads them live for the next header.
    assign pready = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seq_id <= SEQ_ID_RST;
            cfg_reg.short_addr <= SHORT_ADDR_RST;
            cfg_reg.radius <= RADIUS_RST;
            cfg_reg.options <= OPTIONS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SEQ_ID:     cfg_reg.seq_id <= pwdata[7:0];
                REG_SHORT_ADDR: cfg_reg.short_addr <= pwdata[15:0];
                REG_RADIUS:     cfg_reg.radius <= pwdata[7:0];
                REG_OPTIONS:    cfg_reg.options <= pwdata[7:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back: zero-extend the selected register.
    always_comb
    begin
        unique case (reg_idx)
            REG_SEQ_ID:     prdata = {24'h0, cfg_reg.seq_id};
            REG_SHORT_ADDR: prdata = {16'h0, cfg_reg.short_addr};
            REG_RADIUS:     prdata = {24'h0, cfg_reg.radius};
            REG_OPTIONS:    prdata = {24'h0, cfg_reg.options};
            default:        prdata = 32'h0;
        endcase
    end

    // Front: classify each input beat as frame opener or payload, track
    // the bytes left in the open frame, hand one command to the queue.
    atrf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .payload_byte (payload_byte),
        .payload_len  (payload_len),
        .dest_addr    (dest_addr),
        .push_ready   (push_ready),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // Queue: hold commands so the front keeps taking beats while the
    // emitter works through a header.
    atrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: advance through header, payload and checksum positions and
    // drive the registered output beat.
    atrf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .cfg         (cfg_reg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last)
    );

endmodule

// File: rtl/atrf_front.sv
// ---------------------------------------------------------------------------
// atrf_front: input classifier
// Tracks the open frame and turns each accepted beat into one command.
// ---------------------------------------------------------------------------
module atrf_front
    import atrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [7:0]       payload_byte,
    input  logic [LEN_W-1:0] payload_len,
    input  logic [63:0]      dest_addr,
    input  logic             push_ready,
    output logic             push,
    output atrf_cmd_t        push_cmd
);

    logic [LEN_W-1:0] left_reg;
    logic [LEN_W-1:0] left_next;
    logic [LEN_W-1:0] len_sat;

    assign item_ready = push_ready;
    assign push = item_valid && push_ready;
    assign len_sat = (payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len;

    always_comb
    begin
        push_cmd.addr = dest_addr;
        push_cmd.payload = payload_byte;
        push_cmd.len = len_sat;
        left_next = left_reg;
        if (left_reg == '0)
        begin
            push_cmd.hdr = 1'b1;
            push_cmd.has_payload = (len_sat != '0);
            push_cmd.last = (len_sat <= 9'd1);
            if (len_sat != '0)
            begin
                left_next = len_sat - 9'd1;
            end
        end
        else
        begin
            push_cmd.hdr = 1'b0;
            push_cmd.has_payload = 1'b1;
            push_cmd.last = (left_reg == 9'd1);
            left_next = left_reg - 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (push)
        begin
            left_reg <= left_next;
        end
    end

endmodule

// File: rtl/atrf_queue.sv
// ---------------------------------------------------------------------------
// atrf_queue: command queue
// Short FIFO that decouples the classifier from the byte emitter.
// ---------------------------------------------------------------------------
module atrf_queue
    import atrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  atrf_cmd_t push_cmd,
    output logic      push_ready,
    input  logic      pop,
    output logic      head_valid,
    output atrf_cmd_t head_cmd
);

    atrf_cmd_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign push_ready = (count_reg != QUEUE_DEPTH[QPTR_W:0]);
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/atrf_back.sv
// ---------------------------------------------------------------------------
// atrf_back: byte emitter
// Walks each command through its frame positions, one byte per cycle while the
// output is not stalled, keeps the checksum and drives the output register.
// ---------------------------------------------------------------------------
module atrf_back
    import atrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  atrf_cmd_t head_cmd,
    output logic      pop,
    input  atrf_cfg_t cfg,
    output logic      frame_valid,
    input  logic      frame_ready,
    output logic [7:0] frame_byte,
    output logic      frame_last
);

    logic             started_reg;
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       sum_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic             advance;
    logic             done;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       byte_cur;
    logic [7:0]       sum_next;
    logic [15:0]      total;

    assign advance = head_valid && (!valid_reg || frame_ready);
    assign pop = advance && done;
    assign pos = started_reg ? pos_reg : (head_cmd.hdr ? POS_DELIM : POS_PAYLOAD);
    assign total = LEN_OVERHEAD + {{(16-LEN_W){1'b0}}, head_cmd.len};

    always_comb
    begin
        unique case (pos)
            POS_DELIM:    byte_cur = SOF_BYTE;
            POS_LEN_HI:   byte_cur = total[15:8];
            POS_LEN_LO:   byte_cur = total[7:0];
            POS_TYPE:     byte_cur = TX_REQ_TYPE;
            POS_SEQ_ID:   byte_cur = cfg.seq_id;
            POS_ADDR7:    byte_cur = head_cmd.addr[63:56];
            POS_ADDR6:    byte_cur = head_cmd.addr[55:48];
            POS_ADDR5:    byte_cur = head_cmd.addr[47:40];
            POS_ADDR4:    byte_cur = head_cmd.addr[39:32];
            POS_ADDR3:    byte_cur = head_cmd.addr[31:24];
            POS_ADDR2:    byte_cur = head_cmd.addr[23:16];
            POS_ADDR1:    byte_cur = head_cmd.addr[15:8];
            POS_ADDR0:    byte_cur = head_cmd.addr[7:0];
            POS_SHORT_HI: byte_cur = cfg.short_addr[15:8];
            POS_SHORT_LO: byte_cur = cfg.short_addr[7:0];
            POS_RADIUS:   byte_cur = cfg.radius;
            POS_OPTIONS:  byte_cur = cfg.options;
            POS_PAYLOAD:  byte_cur = head_cmd.payload;
            POS_CHECKSUM: byte_cur = ~sum_reg;
            default:      byte_cur = 8'h00;
        endcase
    end

    // step through the positions; skip payload or checksum as the command says
    always_comb
    begin
        done = 1'b0;
        pos_next = pos + 5'd1;
        if (pos == POS_OPTIONS)
        begin
            if (head_cmd.has_payload)
            begin
                pos_next = POS_PAYLOAD;
            end
            else if (head_cmd.last)
            begin
                pos_next = POS_CHECKSUM;
            end
            else
            begin
                done = 1'b1;
            end
        end
        else if (pos == POS_PAYLOAD)
        begin
            done = !head_cmd.last;
        end
        else if (pos >= POS_CHECKSUM)
        begin
            done = 1'b1;
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (pos == POS_DELIM)
        begin
            sum_next = 8'h00;
        end
        else if (pos >= POS_TYPE && pos <= POS_PAYLOAD)
        begin
            sum_next = sum_reg + byte_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pos_reg <= '0;
            sum_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                started_reg <= !done;
                pos_reg <= pos_next;
                sum_reg <= sum_next;
                valid_reg <= 1'b1;
            end
            else if (frame_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_cur;
            last_reg <= (pos == POS_CHECKSUM);
        end
    end

    assign frame_valid = valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule
